// ===== hdl/plin_pkg.sv =====
// Shared types and constants for the piecewise linear interpolator.
package plin_pkg;

  // Width of the shared add/subtract unit: holds any 32-bit difference or sum
  // with sign.
  localparam int unsigned AluW = 34;

  // Mode field codes.
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_EVAL = 1'b1;

  // Saturation limits, signed Q16.16.
  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;

  typedef struct packed {
    logic               mode;
    logic [3:0]         point_index;
    logic signed [31:0] point_in;
    logic signed [31:0] point_out;
    logic signed [31:0] sample;
  } plin_in_t;

  typedef struct packed {
    logic signed [31:0] curve_value;
    logic               saturated;
  } plin_out_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } plin_alu_op_e;

  typedef struct packed {
    logic signed [AluW-1:0] a;
    logic signed [AluW-1:0] b;
    plin_alu_op_e           op;
  } plin_alu_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_DX,
    ST_DEN,
    ST_DY,
    ST_ABS,
    ST_MUL,
    ST_DIV,
    ST_RND,
    ST_INC,
    ST_SUM,
    ST_DONE
  } plin_state_e;

endpackage

// ===== hdl/piecewise_linear_interpolator.sv =====
// Top level of the piecewise linear interpolator over a breakpoint table.
//
//   beat      | signals                          | moves
//   ----------+----------------------------------+-------------------------------
//   input     | in_valid_i / in_ready_o          | plin_in_t: load or evaluate
//   result    | out_valid_o / out_ready_i        | plin_out_t: curve value, clip
//   config    | cfg_we_i, cfg_data_i             | points_in_use, no wait
//
// A load beat writes the breakpoint to the table as the beat is accepted, and
// the block stays ready.
// An evaluate beat walks the table one breakpoint at a time (registered read,
// then compare on the shared adder) until the sample is bracketed. A flat
// result takes the value of the entry where the walk stops; an interpolated
// one adds three differences and an absolute value, one 32x32 multiply, 32
// restoring divide steps on the shared adder, two rounding steps and the
// final sum.
// An evaluate with no points in use goes straight to done with a zero result.
// Reset clears the sequencer, the result valid and points_in_use; the table
// is not cleared. A stalled result sits in the output register; the block
// takes further load beats meanwhile and holds a new result until it drains.
module piecewise_linear_interpolator
  import plin_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  plin_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output plin_out_t out_data_o,
  input  logic      cfg_we_i,
  input  logic [4:0] cfg_data_i
);

  localparam int unsigned AddrW = $clog2(MAX_POINTS);

  logic [4:0]             cfg_q;
  logic [4:0]             n_eff;
  logic                   tbl_we;
  logic [AddrW-1:0]       tbl_raddr;
  logic [63:0]            tbl_rdata;
  plin_alu_req_t          alu_req;
  logic signed [AluW-1:0] alu_res;

  // points_in_use; the user must write it only while idle, the block does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= 5'd0;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_data_i;
    end
  end

  // more points than the table holds acts as a full table
  assign n_eff = (32'(cfg_q) > MAX_POINTS) ? 5'(MAX_POINTS) : cfg_q;

  // loads to a slot past the table are dropped
  assign tbl_we = in_valid_i && in_ready_o && (in_data_i.mode == MODE_LOAD)
                  && (32'(in_data_i.point_index) < MAX_POINTS);

  plin_mem #(
    .Depth (MAX_POINTS),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (AddrW'(in_data_i.point_index)),
    .wdata_i ({in_data_i.point_in, in_data_i.point_out}),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  plin_alu u_alu (
    .req_i (alu_req),
    .res_o (alu_res)
  );

  plin_seq #(
    .AddrW (AddrW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_mode_i   (in_data_i.mode),
    .in_sample_i (in_data_i.sample),
    .n_i         (n_eff),
    .raddr_o     (tbl_raddr),
    .rdata_i     (tbl_rdata),
    .alu_req_o   (alu_req),
    .alu_res_i   (alu_res),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== hdl/plin_alu.sv =====
// Shared signed add/subtract unit used for the datapath compares, differences and sums.
module plin_alu
  import plin_pkg::*;
(
  input  plin_alu_req_t          req_i,
  output logic signed [AluW-1:0] res_o
);

  always_comb begin
    case (req_i.op)
      ALU_ADD: res_o = req_i.a + req_i.b;
      ALU_SUB: res_o = req_i.a - req_i.b;
      default: res_o = req_i.a - req_i.b;
    endcase
  end

endmodule

// ===== hdl/plin_mem.sv =====
// Breakpoint table: one write port, one registered read port.
module plin_mem #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [63:0]      wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [63:0]      rdata_o
);

  logic [63:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hdl/plin_seq.sv =====
// Sequencer and datapath registers: table search, multiply, restoring divide.
module plin_seq
  import plin_pkg::*;
#(
  parameter int unsigned AddrW = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // input beat
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   in_mode_i,
  input  logic signed [31:0]     in_sample_i,
  input  logic [4:0]             n_i,
  // table read
  output logic [AddrW-1:0]       raddr_o,
  input  logic [63:0]            rdata_i,
  // shared unit
  output plin_alu_req_t          alu_req_o,
  input  logic signed [AluW-1:0] alu_res_i,
  // result beat
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output plin_out_t              out_data_o
);

  plin_state_e state_q, state_d;

  logic signed [31:0] sample_q, x0_q, y0_q, x1_q, y1_q, res_q;
  logic [4:0]         n_q, idx_q, cnt_q;
  logic [31:0]        dx_q, den_q, mag_q, rem_q, lo_q, quo_q;
  logic signed [32:0] dy_q;
  logic               neg_q, up_q, sat_q;
  logic               out_valid_q;
  plin_out_t          out_data_q;

  logic signed [31:0] ent_x, ent_y;
  logic               le;          // sample at or below the entry input
  logic               last;        // current entry is the last one in use
  logic [32:0]        div_t;
  logic               div_ge;
  logic               out_free;
  logic               accept;
  logic [63:0]        prod;
  logic               sum_ovf;

  assign ent_x    = rdata_i[63:32];
  assign ent_y    = rdata_i[31:0];
  assign le       = ~alu_res_i[AluW-1];
  assign last     = (idx_q + 5'd1) == n_q;
  assign div_t    = {rem_q, lo_q[31]};
  assign div_ge   = ~alu_res_i[AluW-1];
  assign out_free = ~out_valid_q | out_ready_i;
  assign accept   = in_valid_i & in_ready_o;
  assign prod     = dx_q * mag_q;
  assign sum_ovf  = ~((alu_res_i[33:31] == 3'b000) | (alu_res_i[33:31] == 3'b111));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && in_mode_i == MODE_EVAL) begin
          state_d = (n_i == 5'd0) ? ST_DONE : ST_READ;
        end
      end
      ST_READ: state_d = ST_CMP;
      ST_CMP: begin
        if (idx_q == 5'd0) begin
          state_d = (n_q == 5'd1 || le) ? ST_DONE : ST_READ;
        end else if (le) begin
          state_d = ST_DX;
        end else begin
          state_d = last ? ST_DONE : ST_READ;
        end
      end
      ST_DX:   state_d = ST_DEN;
      ST_DEN:  state_d = ST_DY;
      ST_DY:   state_d = ST_ABS;
      ST_ABS:  state_d = ST_MUL;
      ST_MUL:  state_d = ST_DIV;
      ST_DIV:  state_d = (cnt_q == 5'd31) ? ST_RND : ST_DIV;
      ST_RND:  state_d = ST_INC;
      ST_INC:  state_d = ST_SUM;
      ST_SUM:  state_d = ST_DONE;
      ST_DONE: state_d = out_free ? ST_IDLE : ST_DONE;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs: ready, table address, shared unit operands
  always_comb begin
    in_ready_o   = (state_q == ST_IDLE);
    raddr_o      = AddrW'(idx_q);
    alu_req_o.a  = '0;
    alu_req_o.b  = '0;
    alu_req_o.op = ALU_SUB;
    case (state_q)
      ST_CMP: begin
        alu_req_o.a = {{2{ent_x[31]}}, ent_x};
        alu_req_o.b = {{2{sample_q[31]}}, sample_q};
      end
      ST_DX: begin
        alu_req_o.a = {{2{sample_q[31]}}, sample_q};
        alu_req_o.b = {{2{x0_q[31]}}, x0_q};
      end
      ST_DEN: begin
        alu_req_o.a = {{2{x1_q[31]}}, x1_q};
        alu_req_o.b = {{2{x0_q[31]}}, x0_q};
      end
      ST_DY: begin
        alu_req_o.a = {{2{y1_q[31]}}, y1_q};
        alu_req_o.b = {{2{y0_q[31]}}, y0_q};
      end
      ST_ABS: begin
        alu_req_o.b  = {dy_q[32], dy_q};
        alu_req_o.op = neg_q ? ALU_SUB : ALU_ADD;
      end
      ST_DIV: begin
        alu_req_o.a = {1'b0, div_t};
        alu_req_o.b = {2'b00, den_q};
      end
      ST_RND: begin
        alu_req_o.a = {1'b0, rem_q, 1'b0};
        alu_req_o.b = {2'b00, den_q};
      end
      ST_INC: begin
        alu_req_o.a  = {2'b00, quo_q};
        alu_req_o.b  = {{(AluW-1){1'b0}}, up_q};
        alu_req_o.op = ALU_ADD;
      end
      ST_SUM: begin
        alu_req_o.a  = {{2{y0_q[31]}}, y0_q};
        alu_req_o.b  = {2'b00, quo_q};
        alu_req_o.op = neg_q ? ALU_SUB : ALU_ADD;
      end
      default: begin
        alu_req_o.op = ALU_SUB;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        sample_q <= in_sample_i;
        n_q      <= n_i;
        idx_q    <= 5'd0;
        res_q    <= '0;
        sat_q    <= 1'b0;
      end
      ST_CMP: begin
        res_q <= ent_y;
        sat_q <= 1'b0;
        if (idx_q != 5'd0 && le) begin
          x1_q <= ent_x;
          y1_q <= ent_y;
        end else begin
          x0_q  <= ent_x;
          y0_q  <= ent_y;
          idx_q <= idx_q + 5'd1;
        end
      end
      ST_DX:  dx_q  <= alu_res_i[31:0];
      ST_DEN: den_q <= alu_res_i[31:0];
      ST_DY: begin
        dy_q  <= alu_res_i[32:0];
        neg_q <= alu_res_i[AluW-1];
      end
      ST_ABS: mag_q <= alu_res_i[31:0];
      ST_MUL: begin
        rem_q <= prod[63:32];
        lo_q  <= prod[31:0];
        cnt_q <= 5'd0;
      end
      ST_DIV: begin
        rem_q <= div_ge ? alu_res_i[31:0] : div_t[31:0];
        lo_q  <= {lo_q[30:0], 1'b0};
        quo_q <= {quo_q[30:0], div_ge};
        cnt_q <= cnt_q + 5'd1;
      end
      ST_RND: up_q  <= ~alu_res_i[AluW-1];
      ST_INC: quo_q <= alu_res_i[31:0];
      ST_SUM: begin
        sat_q <= sum_ovf;
        if (sum_ovf) begin
          res_q <= alu_res_i[AluW-1] ? Q_MIN : Q_MAX;
        end else begin
          res_q <= alu_res_i[31:0];
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_data_q.curve_value <= res_q;
          out_data_q.saturated   <= sat_q;
        end
      end
      default: begin
        res_q <= res_q;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
